// ----- rtl/core/liang_barsky_line_clip_defines.svh -----
// ----------------------------------------------------------------------------
// liang_barsky_line_clip_defines
// assertion macros shared by the line clipper rtl
// ----------------------------------------------------------------------------
`ifndef LIANG_BARSKY_LINE_CLIP_DEFINES_SVH
`define LIANG_BARSKY_LINE_CLIP_DEFINES_SVH

// same-cycle implication
`define LBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lbclip_pkg.sv -----
// ----------------------------------------------------------------------------
// lbclip_pkg
// shared constants and types of the line clipper
// ----------------------------------------------------------------------------
`default_nettype none

package lbclip_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int LANES           = 4;

	// class of one parameter ratio n/d
	typedef enum logic [1:0] {
		RC_NEG  = 2'd0,
		RC_OVER = 2'd1,
		RC_EQ   = 2'd2,
		RC_DIV  = 2'd3
	} rcls_t;

endpackage

`default_nettype wire

// ----- rtl/core/lbclip_div_step.sv -----
// ----------------------------------------------------------------------------
// lbclip_div_step
// one restoring division step for all ratio lanes, registered, with stall
// ----------------------------------------------------------------------------
`default_nettype none

`include "liang_barsky_line_clip_defines.svh"

module lbclip_div_step #(
	parameter int EW = 28,
	parameter int QW = 16,
	parameter int PW = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic [PW-1:0]                            in_pay,
	input  wire logic [lbclip_pkg::LANES-1:0][EW-1:0]     in_rem,
	input  wire logic [lbclip_pkg::LANES-1:0][EW-1:0]     in_den,
	input  wire logic [lbclip_pkg::LANES-1:0][QW-1:0]     in_q,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic [PW-1:0]                                 out_pay,
	output logic [lbclip_pkg::LANES-1:0][EW-1:0]          out_rem,
	output logic [lbclip_pkg::LANES-1:0][EW-1:0]          out_den,
	output logic [lbclip_pkg::LANES-1:0][QW-1:0]          out_q
);

	logic                                      v_q;
	logic [lbclip_pkg::LANES-1:0][EW-1:0]      rem_n;
	logic [lbclip_pkg::LANES-1:0][QW-1:0]      q_n;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;

	always_comb begin
		logic [EW-1:0] sh;
		for (int i = 0; i < lbclip_pkg::LANES; i++) begin
			sh = {in_rem[i][EW-2:0], 1'b0};
			if (sh >= in_den[i]) begin
				rem_n[i] = sh - in_den[i];
				q_n[i]   = {in_q[i][QW-2:0], 1'b1};
			end else begin
				rem_n[i] = sh;
				q_n[i]   = {in_q[i][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_pay <= in_pay;
			out_rem <= rem_n;
			out_den <= in_den;
			out_q   <= q_n;
		end
	end

	`LBC_ASSERT_NXT(a_step_hold, clk, arst_n, v_q && !out_ready, v_q, "stalled step lost its beat")
	`LBC_ASSERT_NXT(a_step_load, clk, arst_n, in_valid && in_ready, v_q, "accepted beat not held")
	`LBC_ASSERT_IMP(a_step_rdy, clk, arst_n, !in_ready, v_q && !out_ready, "step blocked without stall")

endmodule

`default_nettype wire

// ----- rtl/core/liang_barsky_line_clip.sv -----
// ----------------------------------------------------------------------------
// liang_barsky_line_clip
// liang-barsky clipper of one segment against the window [-1,1] x [-1,1]
// ----------------------------------------------------------------------------
//  channel   dir  tdata                               tuser
//  s_axis    in   start_x, start_y, end_x, end_y      -
//  m_axis    out  clip_start_x/y, clip_end_x/y        visible
//
//  one segment per cycle while the output is not stalled; stages in order:
//  input stage, classify stage, one division step per fraction bit,
//  parameter select, multiply, interpolate and saturate
//  each stage holds its beat while the next cannot take it; bubbles are squeezed out
//  arst_n clears the valid bits only
// ----------------------------------------------------------------------------
`default_nettype none

`include "liang_barsky_line_clip_defines.svh"

module liang_barsky_line_clip #(
	parameter int COORD_WIDTH = lbclip_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = lbclip_pkg::FRAC_BITS_DEF,
	localparam int DW         = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire logic [DW-1:0] s_axis_tdata,  // start_x, start_y, end_x, end_y
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [DW-1:0]      m_axis_tdata,  // clip_start_x, clip_start_y, clip_end_x, clip_end_y
	output logic [0:0]         m_axis_tuser   // visible
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int EW = ((W > F + 1) ? W : F + 1) + 2;
	localparam int UW = F + 3;
	localparam int NL = lbclip_pkg::LANES;

	localparam logic signed [EW-1:0] ONE_E  = {{(EW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic signed [EW-1:0] NONE_E = -ONE_E;
	localparam logic signed [UW-1:0] ONE_U  = {2'b00, 1'b1, {F{1'b0}}};
	localparam logic signed [W-1:0]  CMAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  CMIN   = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic                           gen;
		logic                           svis;
		lbclip_pkg::rcls_t [NL-1:0]     code;
		logic signed [W-1:0]            cx1;
		logic signed [W-1:0]            cy1;
		logic signed [W-1:0]            cx2;
		logic signed [W-1:0]            cy2;
		logic signed [W:0]              dx;
		logic signed [W:0]              dy;
	} pay_t;

	localparam int PW = $bits(pay_t);

	function automatic logic signed [W-1:0] sat_e(input logic signed [EW-1:0] v);
		if (v > EW'(CMAX))
			return CMAX;
		else if (v < EW'(CMIN))
			return CMIN;
		else
			return v[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_s(input logic signed [W+1:0] v);
		if (v > (W+2)'(CMAX))
			return CMAX;
		else if (v < (W+2)'(CMIN))
			return CMIN;
		else
			return v[W-1:0];
	endfunction

	function automatic logic signed [EW-1:0] clamp_w(input logic signed [EW-1:0] v);
		if (v > ONE_E)
			return ONE_E;
		else if (v < NONE_E)
			return NONE_E;
		else
			return v;
	endfunction

	function automatic logic signed [UW-1:0] u_of(input lbclip_pkg::rcls_t c,
			input logic [F-1:0] q);
		logic signed [UW-1:0] r;
		unique case (c)
			lbclip_pkg::RC_NEG:  r = -UW'(1);
			lbclip_pkg::RC_OVER: r = ONE_U + UW'(1);
			lbclip_pkg::RC_EQ:   r = ONE_U;
			lbclip_pkg::RC_DIV:  r = signed'({3'b000, q});
			default:             r = ONE_U;
		endcase
		return r;
	endfunction

	// ready chain
	logic rdy_s1, rdy_s2, rdy_sc, rdy_sm, rdy_so;
	logic v_s1, v_s2, v_sc, v_sm, v_so;

	// stage 1: differences and ratio numerators
	logic signed [W-1:0]  ix1, iy1, ix2, iy2;
	logic signed [EW-1:0] ex1, ey1, ex2, ey2;
	logic                 x_inc, y_inc;

	logic signed [W-1:0]        x1_s1, y1_s1, x2_s1, y2_s1;
	logic signed [W:0]          dx_s1, dy_s1;
	logic signed [NL-1:0][EW-1:0] n_s1;
	logic [1:0][EW-1:0]         dn_s1;
	logic                       vert_s1, horz_s1;

	assign ix1 = s_axis_tdata[W-1:0];
	assign iy1 = s_axis_tdata[2*W-1:W];
	assign ix2 = s_axis_tdata[3*W-1:2*W];
	assign iy2 = s_axis_tdata[4*W-1:3*W];
	assign ex1 = EW'(ix1);
	assign ey1 = EW'(iy1);
	assign ex2 = EW'(ix2);
	assign ey2 = EW'(iy2);
	assign x_inc = ix2 > ix1;
	assign y_inc = iy2 > iy1;

	assign s_axis_tready = rdy_s1;
	assign rdy_s1 = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			x1_s1   <= ix1;
			y1_s1   <= iy1;
			x2_s1   <= ix2;
			y2_s1   <= iy2;
			dx_s1   <= (W+1)'(ix2) - (W+1)'(ix1);
			dy_s1   <= (W+1)'(iy2) - (W+1)'(iy1);
			n_s1[0] <= x_inc ? (NONE_E - ex1) : (ex1 - ONE_E);
			n_s1[1] <= x_inc ? (ONE_E - ex1) : (ex1 + ONE_E);
			n_s1[2] <= y_inc ? (NONE_E - ey1) : (ey1 - ONE_E);
			n_s1[3] <= y_inc ? (ONE_E - ey1) : (ey1 + ONE_E);
			dn_s1[0] <= x_inc ? unsigned'(ex2 - ex1) : unsigned'(ex1 - ex2);
			dn_s1[1] <= y_inc ? unsigned'(ey2 - ey1) : unsigned'(ey1 - ey2);
			vert_s1 <= ix1 == ix2;
			horz_s1 <= iy1 == iy2;
		end
	end

	// stage 2: ratio class and axis-parallel path
	pay_t                       pay_s2, pay_n2;
	logic [NL-1:0][EW-1:0]      rem_s2, den_s2, rem_n2, den_n2;
	logic [NL-1:0][F-1:0]       q_zero;
	logic [F:0]                 div_v;
	logic [F:0]                 div_r;
	logic [F:0][PW-1:0]         div_p;
	logic [F:0][NL-1:0][EW-1:0] div_rem;
	logic [F:0][NL-1:0][EW-1:0] div_den;
	logic [F:0][NL-1:0][F-1:0]  div_q;

	assign q_zero = '0;
	assign rdy_s2 = !v_s2 || div_r[0];

	always_comb begin
		logic signed [EW-1:0] a1, b1, a2, b2;
		logic                 vert, horz, svis;
		pay_n2 = '0;
		for (int i = 0; i < NL; i++) begin
			den_n2[i] = dn_s1[i/2];
			rem_n2[i] = unsigned'(n_s1[i]);
			if (n_s1[i][EW-1])
				pay_n2.code[i] = lbclip_pkg::RC_NEG;
			else if (unsigned'(n_s1[i]) > dn_s1[i/2])
				pay_n2.code[i] = lbclip_pkg::RC_OVER;
			else if (unsigned'(n_s1[i]) == dn_s1[i/2])
				pay_n2.code[i] = lbclip_pkg::RC_EQ;
			else
				pay_n2.code[i] = lbclip_pkg::RC_DIV;
		end
		vert = vert_s1;
		horz = !vert_s1 && horz_s1;
		// fixed coordinate a, free coordinate pair b
		a1 = vert ? EW'(x1_s1) : EW'(y1_s1);
		b1 = vert ? EW'(y1_s1) : EW'(x1_s1);
		b2 = vert ? EW'(y2_s1) : EW'(x2_s1);
		a2 = a1;
		svis = (a1 <= ONE_E) && (a1 >= NONE_E) &&
			!((b1 > ONE_E) && (b2 > ONE_E)) && !((b1 < NONE_E) && (b2 < NONE_E));
		pay_n2.gen  = !vert && !horz;
		pay_n2.svis = svis;
		pay_n2.dx   = dx_s1;
		pay_n2.dy   = dy_s1;
		if (!vert && !horz) begin
			pay_n2.cx1 = x1_s1;
			pay_n2.cy1 = y1_s1;
			pay_n2.cx2 = x2_s1;
			pay_n2.cy2 = y2_s1;
		end else if (!svis) begin
			pay_n2.cx1 = '0;
			pay_n2.cy1 = '0;
			pay_n2.cx2 = '0;
			pay_n2.cy2 = '0;
		end else if (vert) begin
			pay_n2.cx1 = sat_e(a1);
			pay_n2.cx2 = sat_e(a2);
			pay_n2.cy1 = sat_e(clamp_w(b1));
			pay_n2.cy2 = sat_e(clamp_w(b2));
		end else begin
			pay_n2.cy1 = sat_e(a1);
			pay_n2.cy2 = sat_e(a2);
			pay_n2.cx1 = sat_e(clamp_w(b1));
			pay_n2.cx2 = sat_e(clamp_w(b2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			pay_s2 <= pay_n2;
			rem_s2 <= rem_n2;
			den_s2 <= den_n2;
		end
	end

	// division steps, one quotient bit each
	assign div_v[0]   = v_s2;
	assign div_p[0]   = pay_s2;
	assign div_rem[0] = rem_s2;
	assign div_den[0] = den_s2;
	assign div_q[0]   = q_zero;
	assign div_r[F]   = rdy_sc;

	for (genvar k = 0; k < F; k++) begin : g_div
		lbclip_div_step #(
			.EW(EW),
			.QW(F),
			.PW(PW)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_v[k]),
			.in_ready  (div_r[k]),
			.in_pay    (div_p[k]),
			.in_rem    (div_rem[k]),
			.in_den    (div_den[k]),
			.in_q      (div_q[k]),
			.out_valid (div_v[k+1]),
			.out_ready (div_r[k+1]),
			.out_pay   (div_p[k+1]),
			.out_rem   (div_rem[k+1]),
			.out_den   (div_den[k+1]),
			.out_q     (div_q[k+1])
		);
	end

	// parameter select
	pay_t           pay_d, pay_sc, pay_sm;
	logic [F:0]     umin_sc, umax_sc;
	logic           vis_sc, end_sc, start_sc;
	logic [W-1:0]   magx_sc, magy_sc;
	logic           sgnx_sc, sgny_sc;
	logic           vis_n_c, end_n_c, start_n_c;
	logic [F:0]     umin_n_c, umax_n_c;

	assign pay_d  = pay_t'(div_p[F]);
	assign rdy_sc = !v_sc || rdy_sm;

	always_comb begin
		logic signed [UW-1:0] ue_x, ul_x, ue_y, ul_y, umax, umin;
		logic                 visg;
		ue_x = u_of(pay_d.code[0], div_q[F][0]);
		ul_x = u_of(pay_d.code[1], div_q[F][1]);
		ue_y = u_of(pay_d.code[2], div_q[F][2]);
		ul_y = u_of(pay_d.code[3], div_q[F][3]);
		umax = '0;
		if (ue_x > umax)
			umax = ue_x;
		if (ue_y > umax)
			umax = ue_y;
		umin = ONE_U;
		if (ul_x < umin)
			umin = ul_x;
		if (ul_y < umin)
			umin = ul_y;
		visg = !(umax > umin);
		vis_n_c   = pay_d.gen ? visg : pay_d.svis;
		end_n_c   = pay_d.gen && visg && (umin < ONE_U);
		start_n_c = pay_d.gen && visg && (umax > '0);
		umin_n_c  = umin[F:0];
		umax_n_c  = umax[F:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc <= 1'b0;
		end else if (rdy_sc) begin
			v_sc <= div_v[F];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_sc && div_v[F]) begin
			pay_sc   <= pay_d;
			vis_sc   <= vis_n_c;
			end_sc   <= end_n_c;
			start_sc <= start_n_c;
			umin_sc  <= umin_n_c;
			umax_sc  <= umax_n_c;
			magx_sc  <= pay_d.dx[W] ? W'(-pay_d.dx) : pay_d.dx[W-1:0];
			magy_sc  <= pay_d.dy[W] ? W'(-pay_d.dy) : pay_d.dy[W-1:0];
			sgnx_sc  <= pay_d.dx[W];
			sgny_sc  <= pay_d.dy[W];
		end
	end

	// multiply
	logic [W+F:0] mxe, mye, mxs, mys;
	logic [W:0]   pxe_sm, pye_sm, pxs_sm, pys_sm;
	logic         vis_sm, end_sm, start_sm, sgnx_sm, sgny_sm;

	assign rdy_sm = !v_sm || rdy_so;
	assign mxe = (W+F+1)'(magx_sc) * (W+F+1)'(umin_sc);
	assign mye = (W+F+1)'(magy_sc) * (W+F+1)'(umin_sc);
	assign mxs = (W+F+1)'(magx_sc) * (W+F+1)'(umax_sc);
	assign mys = (W+F+1)'(magy_sc) * (W+F+1)'(umax_sc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
		end else if (rdy_sm) begin
			v_sm <= v_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_sm && v_sc) begin
			pay_sm   <= pay_sc;
			vis_sm   <= vis_sc;
			end_sm   <= end_sc;
			start_sm <= start_sc;
			sgnx_sm  <= sgnx_sc;
			sgny_sm  <= sgny_sc;
			pxe_sm   <= mxe[W+F:F];
			pye_sm   <= mye[W+F:F];
			pxs_sm   <= mxs[W+F:F];
			pys_sm   <= mys[W+F:F];
		end
	end

	// interpolate and saturate
	logic signed [W+1:0] sxe, sye, sxs, sys;
	logic signed [W-1:0] ox1_n, oy1_n, ox2_n, oy2_n;
	logic signed [W-1:0] ox1_so, oy1_so, ox2_so, oy2_so;
	logic                vis_so;

	assign rdy_so = !v_so || m_axis_tready;

	assign sxe = (W+2)'(pay_sm.cx1) + (sgnx_sm ? -signed'({1'b0, pxe_sm}) : signed'({1'b0, pxe_sm}));
	assign sye = (W+2)'(pay_sm.cy1) + (sgny_sm ? -signed'({1'b0, pye_sm}) : signed'({1'b0, pye_sm}));
	assign sxs = (W+2)'(pay_sm.cx1) + (sgnx_sm ? -signed'({1'b0, pxs_sm}) : signed'({1'b0, pxs_sm}));
	assign sys = (W+2)'(pay_sm.cy1) + (sgny_sm ? -signed'({1'b0, pys_sm}) : signed'({1'b0, pys_sm}));

	always_comb begin
		ox1_n = start_sm ? sat_s(sxs) : pay_sm.cx1;
		oy1_n = start_sm ? sat_s(sys) : pay_sm.cy1;
		ox2_n = end_sm ? sat_s(sxe) : pay_sm.cx2;
		oy2_n = end_sm ? sat_s(sye) : pay_sm.cy2;
		if (!vis_sm) begin
			ox1_n = '0;
			oy1_n = '0;
			ox2_n = '0;
			oy2_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_so <= 1'b0;
		end else if (rdy_so) begin
			v_so <= v_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_so && v_sm) begin
			vis_so <= vis_sm;
			ox1_so <= ox1_n;
			oy1_so <= oy1_n;
			ox2_so <= ox2_n;
			oy2_so <= oy2_n;
		end
	end

	assign m_axis_tvalid = v_so;
	assign m_axis_tuser  = vis_so;
	assign m_axis_tdata  = DW'({oy2_so, ox2_so, oy1_so, ox1_so});

	`LBC_ASSERT_IMP(a_rej_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[4*W-1:0] == '0, "rejected beat has nonzero coordinates")
	`LBC_ASSERT_IMP(a_full_stall, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input blocked while output drains")
	`LBC_ASSERT_NXT(a_enter, clk, arst_n, s_axis_tvalid && s_axis_tready, v_s1, "accepted beat missing in first stage")
	`LBC_ASSERT_IMP(a_ends_gen, clk, arst_n, v_sc && (end_sc || start_sc), pay_sc.gen && vis_sc, "interpolation on non-general segment")

endmodule

`default_nettype wire

// ----- bench/liang_barsky_line_clip_test.sv -----
// ----------------------------------------------------------------------------
// liang_barsky_line_clip_test
// self-checking bench: directed and random segments, bursty sender, stalling
// receiver, each beat compared with a listed or in-bench clipper prediction
// ----------------------------------------------------------------------------
`default_nettype none

module liang_barsky_line_clip_test;

	localparam int CW       = lbclip_pkg::COORD_WIDTH_DEF;
	localparam int FB       = lbclip_pkg::FRAC_BITS_DEF;
	localparam int DW       = ((4 * CW + 7) / 8) * 8;
	localparam int N_RAND   = 1300;
	localparam int LATENCY  = FB + 5;
	localparam int WATCHDOG = 2000;
	localparam longint ONE  = longint'(1) << FB;
	localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	typedef struct packed {
		logic [CW-1:0] ey, ex, sy, sx;
	} seg_t;

	typedef struct {
		logic          vis;
		logic [DW-1:0] coords;
	} clip_t;

	typedef struct {
		seg_t  seg;
		logic  known;
		clip_t res;
	} row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [DW-1:0] s_axis_tdata = '0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [DW-1:0] m_axis_tdata;
	logic [0:0]    m_axis_tuser;

	clip_t  clip_queue[$];
	int     errors = 0;
	int     idle_cycles = 0;
	bit     sending_done = 0;
	row_t   rows[$];

	liang_barsky_line_clip dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint param_ratio(longint n, longint d);
		longint rem, q;
		rem = n;
		q = 0;
		if (n < 0) return -1;
		if (n > d) return ONE + 1;
		if (n == d) return ONE;
		for (int i = 0; i < FB; i++) begin
			rem = rem <<< 1;
			q = q <<< 1;
			if (rem >= d) begin
				rem -= d;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic longint scale_by(longint d, longint u);
		longint m;
		m = (d < 0) ? -d : d;
		m = (m * u) >>> FB;
		return (d < 0) ? -m : m;
	endfunction

	function automatic longint win_clamp(longint v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	function automatic logic [CW-1:0] sat(longint v);
		if (v > CMAX) v = CMAX;
		if (v < CMIN) v = CMIN;
		return v[CW-1:0];
	endfunction

	function automatic clip_t clip_segment(seg_t s);
		longint x1, y1, x2, y2, dx, dy, ox1, oy1, ox2, oy2;
		longint ex, lx, ey, ly, umax, umin;
		logic vis;
		clip_t r;
		x1 = longint'(signed'(s.sx));
		y1 = longint'(signed'(s.sy));
		x2 = longint'(signed'(s.ex));
		y2 = longint'(signed'(s.ey));
		dx = x2 - x1;
		dy = y2 - y1;
		ox1 = x1; oy1 = y1; ox2 = x2; oy2 = y2;
		vis = 1'b1;
		if (dx == 0) begin
			if (x1 > ONE || x1 < -ONE) vis = 1'b0;
			else if ((y1 > ONE && y2 > ONE) || (y1 < -ONE && y2 < -ONE)) vis = 1'b0;
			else begin
				oy1 = win_clamp(y1);
				oy2 = win_clamp(y2);
			end
		end else if (dy == 0) begin
			if (y1 > ONE || y1 < -ONE) vis = 1'b0;
			else if ((x1 > ONE && x2 > ONE) || (x1 < -ONE && x2 < -ONE)) vis = 1'b0;
			else begin
				ox1 = win_clamp(x1);
				ox2 = win_clamp(x2);
			end
		end else begin
			if (dx > 0) begin
				ex = param_ratio(-ONE - x1, dx);
				lx = param_ratio(ONE - x1, dx);
			end else begin
				ex = param_ratio(x1 - ONE, -dx);
				lx = param_ratio(x1 + ONE, -dx);
			end
			if (dy > 0) begin
				ey = param_ratio(-ONE - y1, dy);
				ly = param_ratio(ONE - y1, dy);
			end else begin
				ey = param_ratio(y1 - ONE, -dy);
				ly = param_ratio(y1 + ONE, -dy);
			end
			umax = 0;
			umin = ONE;
			if (ex > umax) umax = ex;
			if (ey > umax) umax = ey;
			if (lx < umin) umin = lx;
			if (ly < umin) umin = ly;
			if (umax > umin) vis = 1'b0;
			else begin
				if (umin < ONE) begin
					ox2 = x1 + scale_by(dx, umin);
					oy2 = y1 + scale_by(dy, umin);
				end
				if (umax > 0) begin
					ox1 = x1 + scale_by(dx, umax);
					oy1 = y1 + scale_by(dy, umax);
				end
			end
		end
		if (!vis) begin
			ox1 = 0; oy1 = 0; ox2 = 0; oy2 = 0;
		end
		r.vis = vis;
		r.coords = '0;
		r.coords[4*CW-1:0] = {sat(oy2), sat(ox2), sat(oy1), sat(ox1)};
		return r;
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(9))
			0: return CW'($urandom());
			1, 2: return CW'(longint'($urandom_range(2 * ONE + 8)) - ONE - 4);
			3: return $urandom_range(1) ? CW'(ONE) : CW'(-ONE);
			default: return CW'(longint'($urandom_range(6 * ONE)) - 3 * ONE);
		endcase
	endfunction

	function automatic seg_t rand_seg();
		seg_t s;
		s.sx = rand_coord();
		s.sy = rand_coord();
		s.ex = rand_coord();
		s.ey = rand_coord();
		case ($urandom_range(7))
			0: s.ex = s.sx;
			1: s.ey = s.sy;
			2: begin
				s.ex = s.sx;
				s.ey = s.sy;
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic row_t mk(longint sx, longint sy, longint ex, longint ey,
		logic known = 1'b0, logic vis = 1'b0, longint cx1 = 0, longint cy1 = 0,
		longint cx2 = 0, longint cy2 = 0);
		row_t r;
		r.seg = {CW'(ey), CW'(ex), CW'(sy), CW'(sx)};
		r.known = known;
		r.res.vis = vis;
		r.res.coords = '0;
		r.res.coords[4*CW-1:0] = {CW'(cy2), CW'(cx2), CW'(cy1), CW'(cx1)};
		return r;
	endfunction

	function automatic void add_row(row_t r);
		rows.insert(rows.size(), r);
	endfunction

	initial begin
		add_row(mk(0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
		add_row(mk(CMAX, CMAX, CMAX, CMAX, 1));
		add_row(mk(CMIN, CMIN, CMIN, CMIN, 1));
		add_row(mk(CMIN, CMIN, CMAX, CMAX));
		add_row(mk(CMAX, CMIN, CMIN, CMAX));
		add_row(mk(ONE, ONE, ONE, ONE, 1, 1, ONE, ONE, ONE, ONE));
		add_row(mk(ONE + 1, 0, ONE + 1, 0, 1));
		add_row(mk(0, CMIN, 0, CMAX, 1, 1, 0, -ONE, 0, ONE));
		add_row(mk(CMIN, 0, CMAX, 0, 1, 1, -ONE, 0, ONE, 0));
		add_row(mk(0, ONE + 1, 0, CMAX, 1));
		add_row(mk(0, -ONE - 1, 0, CMIN, 1));
		add_row(mk(ONE + 1, 0, CMAX, 0, 1));
		add_row(mk(-ONE - 1, 0, CMIN, 0, 1));
		add_row(mk(ONE + 1, 0, ONE + 1, 5));
		add_row(mk(0, -ONE - 1, 5, -ONE - 1));
		add_row(mk(-2 * ONE, -2 * ONE, 2 * ONE, 2 * ONE));
		add_row(mk(2 * ONE, 0, 0, 2 * ONE));
		add_row(mk(3 * ONE, 0, 0, 3 * ONE));
		add_row(mk(-ONE, 0, 0, ONE));
		add_row(mk(-ONE / 2, -ONE / 3, ONE / 2, ONE / 5));
		add_row(mk(-3, 7, 5 * ONE, -4 * ONE + 1));
		add_row(mk(ONE, -ONE, -ONE, ONE));
		add_row(mk(-1, 1, 1, -1));
		add_row(mk(-8388608 + 1, 8388607, 1, -1));
		for (int i = 0; i < N_RAND; i++) begin
			row_t r;
			r.seg = rand_seg();
			r.known = 1'b0;
			add_row(r);
		end
	end

	// sender: bursts and gaps
	initial begin
		int burst, gap, idx;
		idx = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (idx < rows.size()) begin
			burst = $urandom_range(40, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
			while (burst > 0 && idx < rows.size()) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= DW'(rows[idx].seg);
				@(posedge clk);
				if (s_axis_tready) begin
					clip_queue.insert(clip_queue.size(), rows[idx].known ? rows[idx].res
						: clip_segment(rows[idx].seg));
					idx++;
					burst--;
				end
			end
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
		sending_done = 1;
	end

	// receiver: stall pattern of its own
	always @(posedge clk) begin
		int phase;
		phase = $urandom_range(15);
		if (phase < 8) m_axis_tready <= 1'b1;
		else if (phase < 12) m_axis_tready <= ($urandom_range(1) == 1);
		else m_axis_tready <= 1'b0;
	end

	always @(posedge clk) begin
		clip_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (clip_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat vis=%0b data=%h", $time,
					m_axis_tuser, m_axis_tdata);
			end else begin
				want = clip_queue.pop_front();
				if (m_axis_tuser[0] !== want.vis) begin
					errors++;
					$display("%0t: visible expected %0b actual %0b", $time,
						want.vis, m_axis_tuser[0]);
				end
				for (int k = 0; k < 4; k++) begin
					if (m_axis_tdata[k*CW +: CW] !== want.coords[k*CW +: CW]) begin
						errors++;
						$display("%0t: coord %0d expected %h actual %h", $time, k,
							want.coords[k*CW +: CW], m_axis_tdata[k*CW +: CW]);
					end
				end
			end
		end
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("liang_barsky_line_clip: mismatch");
			$finish;
		end
	end

	initial begin
		wait (sending_done);
		while (clip_queue.size() != 0) @(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);
		if (errors == 0 && clip_queue.size() == 0) begin
			$display("liang_barsky_line_clip: match");
		end else begin
			$display("liang_barsky_line_clip: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
